// ===== rtl/psst_pkg.sv =====
// ----------------------------------------------------------------------------
// psst_pkg: shared types and constants of the signal statistics table
// Item and entry layouts, item kinds, engine states and field limits.
// ----------------------------------------------------------------------------
package psst_pkg;

	localparam int TABLE_ENTRIES_DEF = 64;
	localparam int QUEUE_DEPTH       = 2;

	localparam int ADDR_W  = 48;
	localparam int CHAN_W  = 4;
	localparam int RSSI_W  = 8;
	localparam int SUM_W   = 32;
	localparam int COUNT_W = 24;

	localparam logic OP_ACCUMULATE = 1'b0;
	localparam logic OP_FLUSH      = 1'b1;

	localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
	localparam logic [SUM_W-1:0]   SUM_MAX   = {1'b0, {(SUM_W-1){1'b1}}};
	localparam logic [SUM_W-1:0]   SUM_MIN   = {1'b1, {(SUM_W-1){1'b0}}};

	typedef enum logic {
		KIND_ACC,
		KIND_FLUSH
	} kind_t;

	typedef struct packed {
		kind_t                     kind;
		logic [ADDR_W-1:0]         addr;
		logic [CHAN_W-1:0]         chan;
		logic signed [RSSI_W-1:0]  rssi;
	} item_t;

	typedef struct packed {
		logic [ADDR_W-1:0]         addr;
		logic [CHAN_W-1:0]         chan;
		logic [SUM_W-1:0]          sum;
		logic [COUNT_W-1:0]        count;
	} entry_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_UPDATE,
		ST_APPEND,
		ST_FLUSH
	} state_t;

endpackage

// ===== rtl/psst_in_if.sv =====
// ----------------------------------------------------------------------------
// psst_in_if: sample channel
// Valid/ready channel carrying one accumulate or flush item per beat.
// ----------------------------------------------------------------------------
interface psst_in_if;
	logic                                valid;
	logic                                ready;
	logic                                operation;
	logic [psst_pkg::ADDR_W-1:0]         sender_address;
	logic [psst_pkg::CHAN_W-1:0]         radio_channel;
	logic signed [psst_pkg::RSSI_W-1:0]  signal_strength;

	modport source (
		output valid, operation, sender_address, radio_channel, signal_strength,
		input  ready
	);
	modport sink (
		input  valid, operation, sender_address, radio_channel, signal_strength,
		output ready
	);
endinterface

// ===== rtl/psst_out_if.sv =====
// ----------------------------------------------------------------------------
// psst_out_if: result channel
// Valid/ready channel carrying one flushed table entry per beat.
// ----------------------------------------------------------------------------
interface psst_out_if;
	logic                                valid;
	logic                                ready;
	logic [psst_pkg::ADDR_W-1:0]         entry_address;
	logic [psst_pkg::CHAN_W-1:0]         entry_channel;
	logic signed [psst_pkg::SUM_W-1:0]   strength_sum;
	logic [psst_pkg::COUNT_W-1:0]        sample_count;
	logic                                last_entry;

	modport source (
		output valid, entry_address, entry_channel, strength_sum, sample_count,
		       last_entry,
		input  ready
	);
	modport sink (
		input  valid, entry_address, entry_channel, strength_sum, sample_count,
		       last_entry,
		output ready
	);
endinterface

// ===== rtl/psst_front.sv =====
// ----------------------------------------------------------------------------
// psst_front: intake and item queue
// Takes sample beats, classifies them by operation and queues them for the
// table engine.
// ----------------------------------------------------------------------------
module psst_front (
	input  logic            clk,
	input  logic            arst_n,
	psst_in_if.sink         sample,
	output logic            item_valid,
	output psst_pkg::item_t item,
	input  logic            item_pop
);

	localparam int PTR_W = (psst_pkg::QUEUE_DEPTH > 1) ? $clog2(psst_pkg::QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(psst_pkg::QUEUE_DEPTH + 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(psst_pkg::QUEUE_DEPTH);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(psst_pkg::QUEUE_DEPTH - 1);

	psst_pkg::item_t  queue_q [psst_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             push;
	logic             pop;
	psst_pkg::item_t  in_item;

	assign sample.ready = (cnt_q != CNT_FULL);
	assign push         = sample.valid && sample.ready;
	assign pop          = item_pop && item_valid;
	assign item_valid   = (cnt_q != '0);
	assign item         = queue_q[rd_ptr_q];

	always_comb begin
		in_item.kind = (sample.operation == psst_pkg::OP_FLUSH) ?
		               psst_pkg::KIND_FLUSH : psst_pkg::KIND_ACC;
		in_item.addr = sample.sender_address;
		in_item.chan = sample.radio_channel;
		in_item.rssi = sample.signal_strength;
	end

	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/psst_engine.sv =====
// ----------------------------------------------------------------------------
// psst_engine: table engine
// Holds the entry memory, searches it one entry a cycle, updates or opens
// entries and streams the table out on a flush.
// ----------------------------------------------------------------------------
module psst_engine #(
	parameter int TABLE_ENTRIES = psst_pkg::TABLE_ENTRIES_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            item_valid,
	input  psst_pkg::item_t item,
	output logic            item_pop,
	psst_out_if.source      result
);

	localparam int IDX_W  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int FILL_W = $clog2(TABLE_ENTRIES + 1);
	localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(TABLE_ENTRIES);

	psst_pkg::entry_t mem [TABLE_ENTRIES];

	psst_pkg::state_t  state_q, state_d;
	logic [FILL_W-1:0] fill_q, fill_d;
	logic [FILL_W-1:0] idx_q, idx_d;
	logic [FILL_W-1:0] idx_next;
	psst_pkg::item_t   cur_q;
	psst_pkg::entry_t  rd_q;
	logic              cur_load;

	logic              rd_en;
	logic [FILL_W-1:0] rd_addr;
	logic              wr_en;
	logic [FILL_W-1:0] wr_addr;
	psst_pkg::entry_t  wr_data;

	logic              out_valid_q;
	psst_pkg::entry_t  out_entry_q;
	logic              out_last_q;
	logic              out_load;
	logic              out_last_d;

	logic                       hit;
	logic [psst_pkg::SUM_W-1:0] rssi_ext;
	logic [psst_pkg::SUM_W:0]   sum_wide;
	logic [psst_pkg::SUM_W-1:0] sum_sat;
	logic [psst_pkg::COUNT_W-1:0] count_inc;

	assign idx_next = idx_q + 1'b1;
	assign hit      = (rd_q.addr == cur_q.addr) && (rd_q.chan == cur_q.chan);
	assign rssi_ext = {{(psst_pkg::SUM_W - psst_pkg::RSSI_W){cur_q.rssi[psst_pkg::RSSI_W-1]}},
	                   cur_q.rssi};
	assign sum_wide = {rd_q.sum[psst_pkg::SUM_W-1], rd_q.sum} +
	                  {rssi_ext[psst_pkg::SUM_W-1], rssi_ext};

	always_comb begin
		if (sum_wide[psst_pkg::SUM_W] != sum_wide[psst_pkg::SUM_W-1]) begin
			sum_sat = sum_wide[psst_pkg::SUM_W] ? psst_pkg::SUM_MIN : psst_pkg::SUM_MAX;
		end else begin
			sum_sat = sum_wide[psst_pkg::SUM_W-1:0];
		end
		count_inc = (rd_q.count == psst_pkg::COUNT_MAX) ? rd_q.count : rd_q.count + 1'b1;
	end

	always_comb begin
		state_d    = state_q;
		fill_d     = fill_q;
		idx_d      = idx_q;
		cur_load   = 1'b0;
		item_pop   = 1'b0;
		rd_en      = 1'b0;
		rd_addr    = '0;
		wr_en      = 1'b0;
		wr_addr    = '0;
		wr_data    = '0;
		out_load   = 1'b0;
		out_last_d = 1'b0;
		case (state_q)
			psst_pkg::ST_IDLE: begin
				if (item_valid) begin
					item_pop = 1'b1;
					cur_load = 1'b1;
					idx_d    = '0;
					if (fill_q == '0) begin
						state_d = (item.kind == psst_pkg::KIND_FLUSH) ?
						          psst_pkg::ST_IDLE : psst_pkg::ST_APPEND;
					end else begin
						rd_en   = 1'b1;
						state_d = (item.kind == psst_pkg::KIND_FLUSH) ?
						          psst_pkg::ST_FLUSH : psst_pkg::ST_SEARCH;
					end
				end
			end
			psst_pkg::ST_SEARCH: begin
				if (hit) begin
					state_d = psst_pkg::ST_UPDATE;
				end else if (idx_next < fill_q) begin
					rd_en   = 1'b1;
					rd_addr = idx_next;
					idx_d   = idx_next;
				end else if (fill_q != FILL_MAX) begin
					state_d = psst_pkg::ST_APPEND;
				end else begin
					state_d = psst_pkg::ST_IDLE;
				end
			end
			psst_pkg::ST_UPDATE: begin
				wr_en         = 1'b1;
				wr_addr       = idx_q;
				wr_data.addr  = rd_q.addr;
				wr_data.chan  = rd_q.chan;
				wr_data.sum   = sum_sat;
				wr_data.count = count_inc;
				state_d       = psst_pkg::ST_IDLE;
			end
			psst_pkg::ST_APPEND: begin
				wr_en         = 1'b1;
				wr_addr       = fill_q;
				wr_data.addr  = cur_q.addr;
				wr_data.chan  = cur_q.chan;
				wr_data.sum   = rssi_ext;
				wr_data.count = psst_pkg::COUNT_W'(1);
				fill_d        = fill_q + 1'b1;
				state_d       = psst_pkg::ST_IDLE;
			end
			psst_pkg::ST_FLUSH: begin
				if (!out_valid_q || result.ready) begin
					out_load   = 1'b1;
					out_last_d = (idx_next == fill_q);
					if (idx_next == fill_q) begin
						fill_d  = '0;
						state_d = psst_pkg::ST_IDLE;
					end else begin
						rd_en   = 1'b1;
						rd_addr = idx_next;
						idx_d   = idx_next;
					end
				end
			end
			default: begin
				state_d = psst_pkg::ST_IDLE;
			end
		endcase
	end

	// entry memory, registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr[IDX_W-1:0]] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr[IDX_W-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (cur_load) begin
			cur_q <= item;
		end
		if (out_load) begin
			out_entry_q <= rd_q;
			out_last_q  <= out_last_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= psst_pkg::ST_IDLE;
			fill_q      <= '0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			fill_q  <= fill_d;
			idx_q   <= idx_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign result.valid         = out_valid_q;
	assign result.entry_address = out_entry_q.addr;
	assign result.entry_channel = out_entry_q.chan;
	assign result.strength_sum  = out_entry_q.sum;
	assign result.sample_count  = out_entry_q.count;
	assign result.last_entry    = out_last_q;

endmodule

// ===== rtl/per_source_signal_stats_table.sv =====
// ----------------------------------------------------------------------------
// per_source_signal_stats_table: received-signal statistics per sender
// Keeps a sum and a count of signal strengths per sender address and channel
// and dumps the table on a flush beat.
// ----------------------------------------------------------------------------
// Sample beats enter a two-deep queue and are handled one at a time by the
// table engine, which walks the filled entries of a single-port memory one
// entry a cycle. An accumulate beat compares the entries in order up to and
// including the hit, or all filled entries on a miss, then updates the hit
// entry or appends a new one; a miss into an empty table appends at once. A
// miss on a full table is dropped. A flush streams out the filled entries,
// one result beat a cycle while the result side keeps up; the final beat
// carries last_entry. A flush of an empty table gives no beat. Sum and count
// saturate. The queue keeps taking beats while the engine works, until it is
// full.
// ----------------------------------------------------------------------------
module per_source_signal_stats_table #(
	parameter int TABLE_ENTRIES = psst_pkg::TABLE_ENTRIES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	psst_in_if.sink     sample,
	psst_out_if.source  result
);

	logic            item_valid;
	logic            item_pop;
	psst_pkg::item_t item;

	psst_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.sample     (sample),
		.item_valid (item_valid),
		.item       (item),
		.item_pop   (item_pop)
	);

	psst_engine #(
		.TABLE_ENTRIES (TABLE_ENTRIES)
	) u_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item       (item),
		.item_pop   (item_pop),
		.result     (result)
	);

endmodule

// ===== dv/per_source_signal_stats_table_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// per_source_signal_stats_table_tb: self-checking bench for the stats table
// Drives sample and flush beats over the input channel. A behavioural copy of
// the table predicts every flushed entry, and each result beat is checked
// against the oldest prediction. Runs directed extremes, a full-table pass and
// random traffic under several idle and back-pressure mixes.
// ----------------------------------------------------------------------------
module per_source_signal_stats_table_tb;

	localparam int N_ENTRIES   = psst_pkg::TABLE_ENTRIES_DEF;
	localparam int DRAIN_WAIT  = 4 * N_ENTRIES + 40;

	typedef struct packed {
		logic [psst_pkg::ADDR_W-1:0]        addr;
		logic [psst_pkg::CHAN_W-1:0]        chan;
		logic signed [psst_pkg::SUM_W-1:0]  sum;
		logic [psst_pkg::COUNT_W-1:0]       count;
		logic                               last;
	} stat_entry_t;

	logic clk = 1'b0;
	logic arst_n;

	psst_in_if  sample_ch();
	psst_out_if result_ch();

	per_source_signal_stats_table #(
		.TABLE_ENTRIES(N_ENTRIES)
	) u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.sample (sample_ch),
		.result (result_ch)
	);

	always #4 clk = ~clk;

	// behavioural table
	logic [psst_pkg::ADDR_W-1:0]        tbl_addr  [N_ENTRIES];
	logic [psst_pkg::CHAN_W-1:0]        tbl_chan  [N_ENTRIES];
	logic signed [psst_pkg::SUM_W-1:0]  tbl_sum   [N_ENTRIES];
	logic [psst_pkg::COUNT_W-1:0]       tbl_count [N_ENTRIES];
	int                                 tbl_fill;

	stat_entry_t pending_entries[$];

	int send_idle_pct;
	int stall_pct;
	int beats_sent;
	int flushes_sent;
	int entries_checked;
	int mismatches;

	function automatic void update_stats_model(input psst_pkg::item_t it);
		int     hit;
		longint acc;
		stat_entry_t e;
		if (it.kind == psst_pkg::KIND_FLUSH) begin
			for (int i = 0; i < tbl_fill; i++) begin
				e.addr  = tbl_addr[i];
				e.chan  = tbl_chan[i];
				e.sum   = tbl_sum[i];
				e.count = tbl_count[i];
				e.last  = (i == tbl_fill - 1);
				pending_entries.push_back(e);
			end
			tbl_fill = 0;
		end else begin
			hit = -1;
			for (int i = 0; i < tbl_fill; i++) begin
				if (hit < 0 && tbl_addr[i] == it.addr && tbl_chan[i] == it.chan)
					hit = i;
			end
			if (hit >= 0) begin
				acc = longint'(tbl_sum[hit]) + longint'($signed(it.rssi));
				if (acc > longint'($signed(psst_pkg::SUM_MAX)))
					acc = longint'($signed(psst_pkg::SUM_MAX));
				if (acc < longint'($signed(psst_pkg::SUM_MIN)))
					acc = longint'($signed(psst_pkg::SUM_MIN));
				tbl_sum[hit] = acc[psst_pkg::SUM_W-1:0];
				if (tbl_count[hit] != psst_pkg::COUNT_MAX)
					tbl_count[hit] = tbl_count[hit] + 1'b1;
			end else if (tbl_fill < N_ENTRIES) begin
				tbl_addr[tbl_fill]  = it.addr;
				tbl_chan[tbl_fill]  = it.chan;
				tbl_sum[tbl_fill]   = psst_pkg::SUM_W'($signed(it.rssi));
				tbl_count[tbl_fill] = psst_pkg::COUNT_W'(1);
				tbl_fill++;
			end
		end
	endfunction

	function automatic psst_pkg::item_t make_item(input psst_pkg::kind_t kind,
			input logic [psst_pkg::ADDR_W-1:0] addr,
			input logic [psst_pkg::CHAN_W-1:0] chan,
			input logic [psst_pkg::RSSI_W-1:0] rssi);
		psst_pkg::item_t it;
		it.kind = kind;
		it.addr = addr;
		it.chan = chan;
		it.rssi = rssi;
		return it;
	endfunction

	function automatic logic [psst_pkg::ADDR_W-1:0] random_addr();
		return {16'($urandom), 32'($urandom)};
	endfunction

	// called just after a rising edge; returns just after the accepting edge
	task automatic send_beat(input psst_pkg::item_t it);
		int gap;
		gap = 0;
		while ($urandom_range(99) < send_idle_pct)
			gap++;
		if (gap > 0) begin
			sample_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample_ch.valid           <= 1'b1;
		sample_ch.operation       <= (it.kind == psst_pkg::KIND_FLUSH) ?
		                             psst_pkg::OP_FLUSH : psst_pkg::OP_ACCUMULATE;
		sample_ch.sender_address  <= it.addr;
		sample_ch.radio_channel   <= it.chan;
		sample_ch.signal_strength <= it.rssi;
		do
			@(posedge clk);
		while (!sample_ch.ready);
		update_stats_model(it);
		beats_sent++;
		if (it.kind == psst_pkg::KIND_FLUSH)
			flushes_sent++;
	endtask

	task automatic set_phase(input int idle_pct, input int hold_pct);
		send_idle_pct = idle_pct;
		stall_pct     = hold_pct;
	endtask

	task automatic test_field_extremes();
		logic [psst_pkg::ADDR_W-1:0] all_ones;
		all_ones = '1;
		send_beat(make_item(psst_pkg::KIND_ACC, '0, '0, 8'h80));
		send_beat(make_item(psst_pkg::KIND_ACC, '0, '0, 8'h80));
		send_beat(make_item(psst_pkg::KIND_ACC, all_ones, 4'hf, 8'h7f));
		send_beat(make_item(psst_pkg::KIND_ACC, all_ones, 4'hf, 8'h7f));
		send_beat(make_item(psst_pkg::KIND_ACC, all_ones, 4'h0, 8'h00));
		send_beat(make_item(psst_pkg::KIND_ACC, '0, 4'hf, 8'hff));
		send_beat(make_item(psst_pkg::KIND_ACC, 48'h5555_5555_5555, 4'ha, 8'h55));
		send_beat(make_item(psst_pkg::KIND_ACC, 48'haaaa_aaaa_aaaa, 4'h5, 8'haa));
		send_beat(make_item(psst_pkg::KIND_ACC, 48'h5555_5555_5555, 4'ha, 8'h80));
		// flush carries junk in the ignored fields
		send_beat(make_item(psst_pkg::KIND_FLUSH, all_ones, 4'hf, 8'hff));
		// empty table: no beat out
		send_beat(make_item(psst_pkg::KIND_FLUSH, 48'h1234_5678_9abc, 4'h3, 8'h11));
		send_beat(make_item(psst_pkg::KIND_ACC, 48'h0000_0000_0001, 4'h8, 8'h01));
		send_beat(make_item(psst_pkg::KIND_FLUSH, '0, '0, '0));
	endtask

	task automatic test_table_full();
		logic [psst_pkg::ADDR_W-1:0] first_addr;
		logic [psst_pkg::ADDR_W-1:0] last_addr;
		logic [psst_pkg::ADDR_W-1:0] a;
		for (int i = 0; i < N_ENTRIES; i++) begin
			a = random_addr();
			a[psst_pkg::ADDR_W-1 -: 6] = 6'(i);
			if (i == 0)
				first_addr = a;
			last_addr = a;
			send_beat(make_item(psst_pkg::KIND_ACC, a, 4'(i), 8'($urandom)));
		end
		// misses on a full table are dropped
		for (int i = 0; i < 4; i++)
			send_beat(make_item(psst_pkg::KIND_ACC, random_addr() | {1'b1, 47'b0}, 4'(i),
				8'($urandom)));
		send_beat(make_item(psst_pkg::KIND_ACC, last_addr, 4'(N_ENTRIES - 1), 8'h80));
		send_beat(make_item(psst_pkg::KIND_ACC, first_addr, 4'h0, 8'h7f));
		send_beat(make_item(psst_pkg::KIND_ACC, first_addr, 4'h1, 8'h7f));
		send_beat(make_item(psst_pkg::KIND_FLUSH, random_addr(), 4'($urandom),
			8'($urandom)));
	endtask

	task automatic test_random_traffic(input int n_items);
		logic [psst_pkg::ADDR_W-1:0] pool_addr[6];
		logic [psst_pkg::CHAN_W-1:0] pool_chan[6];
		int                          pick;
		int                          roll;
		for (int i = 0; i < 6; i++) begin
			pool_addr[i] = random_addr();
			pool_chan[i] = 4'($urandom);
		end
		for (int n = 0; n < n_items; n++) begin
			roll = $urandom_range(99);
			pick = $urandom_range(5);
			if (roll < 10)
				send_beat(make_item(psst_pkg::KIND_FLUSH, random_addr(), 4'($urandom),
					8'($urandom)));
			else if (roll < 25)
				send_beat(make_item(psst_pkg::KIND_ACC, random_addr(), 4'($urandom),
					8'($urandom)));
			else if (roll < 32)
				send_beat(make_item(psst_pkg::KIND_ACC, pool_addr[pick], 4'($urandom),
					8'($urandom)));
			else
				send_beat(make_item(psst_pkg::KIND_ACC, pool_addr[pick], pool_chan[pick],
					8'($urandom)));
		end
		send_beat(make_item(psst_pkg::KIND_FLUSH, random_addr(), 4'($urandom),
			8'($urandom)));
	endtask

	always @(posedge clk)
		result_ch.ready <= ($urandom_range(99) >= stall_pct);

	always @(posedge clk) begin : entry_check
		stat_entry_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			entries_checked++;
			if (pending_entries.size() == 0) begin
				$error("unexpected result beat: address %h channel %0d",
					result_ch.entry_address, result_ch.entry_channel);
				mismatches++;
			end else begin
				want = pending_entries.pop_front();
				if (result_ch.entry_address !== want.addr) begin
					$error("entry_address: expected %h, got %h", want.addr,
						result_ch.entry_address);
					mismatches++;
				end
				if (result_ch.entry_channel !== want.chan) begin
					$error("entry_channel: expected %0d, got %0d", want.chan,
						result_ch.entry_channel);
					mismatches++;
				end
				if (result_ch.strength_sum !== want.sum) begin
					$error("strength_sum: expected %0d, got %0d", want.sum,
						result_ch.strength_sum);
					mismatches++;
				end
				if (result_ch.sample_count !== want.count) begin
					$error("sample_count: expected %0d, got %0d", want.count,
						result_ch.sample_count);
					mismatches++;
				end
				if (result_ch.last_entry !== want.last) begin
					$error("last_entry: expected %0d, got %0d", want.last,
						result_ch.last_entry);
					mismatches++;
				end
			end
		end
	end

	initial begin
		#4_000_000;
		$display("timeout with %0d entries outstanding", pending_entries.size());
		$display("per_source_signal_stats_table regression: fail");
		$finish;
	end

	initial begin
		arst_n                    <= 1'b0;
		sample_ch.valid           <= 1'b0;
		sample_ch.operation       <= psst_pkg::OP_ACCUMULATE;
		sample_ch.sender_address  <= '0;
		sample_ch.radio_channel   <= '0;
		sample_ch.signal_strength <= '0;
		tbl_fill        = 0;
		beats_sent      = 0;
		flushes_sent    = 0;
		entries_checked = 0;
		mismatches      = 0;
		set_phase(0, 0);
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_field_extremes();
		set_phase(0, 56);
		test_table_full();

		set_phase(0, 0);
		test_random_traffic(5);
		set_phase(56, 0);
		test_random_traffic(5);
		set_phase(0, 56);
		test_random_traffic(5);
		set_phase(6, 6);
		test_random_traffic(5);

		sample_ch.valid <= 1'b0;
		while (pending_entries.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		$display("sent %0d beats (%0d flushes); checked %0d entry beats", beats_sent,
			flushes_sent, entries_checked);
		$display("covered field extremes, empty and full table, dropped misses, stalls");
		if (mismatches == 0 && pending_entries.size() == 0)
			$display("per_source_signal_stats_table regression: pass");
		else
			$display("per_source_signal_stats_table regression: fail");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/psst_pkg.sv
rtl/psst_in_if.sv
rtl/psst_out_if.sv
rtl/psst_front.sv
rtl/psst_engine.sv
rtl/per_source_signal_stats_table.sv
dv/per_source_signal_stats_table_tb.sv
